// File: hw/rtl/chr_pkg.sv
// Package for the consistent-hash ring: payload structs, op/status codes,
// FNV-1a constants and the mix function. No dependencies.
package chr_pkg;

  localparam int VNODES_DEF    = 8;
  localparam int MAX_NODES_DEF = 16;
  localparam int MAX_NAME_DEF  = 32;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FOUND = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [1:0] operation;
    logic [3:0] node_slot;
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  owner_slot;
    logic [31:0] key_digest;
  } out_item_t;

  // Commands from front to back.
  typedef enum logic [1:0] {
    CMD_ADD,
    CMD_LOOKUP,
    CMD_REMOVE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [3:0]  slot;
    logic [31:0] hash;
  } cmd_t;

  typedef enum logic [2:0] {
    FE_IDLE,
    FE_NAME,
    FE_COLON,
    FE_TENS,
    FE_ONES,
    FE_PUSH
  } fe_state_t;

  typedef enum logic [1:0] {
    BE_IDLE,
    BE_SCAN,
    BE_WRITE,
    BE_RESULT
  } be_state_t;

  // One FNV-1a step, the byte sign-extended as a signed char.
  function automatic logic [31:0] fnv_mix(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = {{24{b[7]}}, b};
    return (h ^ x) * FNV_PRIME;
  endfunction

endpackage

// File: hw/rtl/consistent_hash_ring_core.sv
// Consistent-hash ring top level: front end, command queue, back end.
// Depends on chr_pkg, chr_front, chr_queue, chr_back.
//
// Name bytes (op 0) are stored; on the last one the front end hashes the
// name once, the colon included, then each virtual node through the TENS,
// ONES and PUSH states, and queues one insert per virtual node.
// The back end scans all VNODES*MAX_NODES ring entries through one read port
// for every command, lookup, remove and insert alike, so an add costs VNODES
// such scans plus its result, and the back end sets the pace. Key bytes
// (op 1) are accepted whenever the front end is idle; a final key byte or a
// remove, once the front end is idle, waits only for room in the two-entry
// queue. Reset clears the ring at once through per-entry valid bits. Op 3
// is dropped with no result.
module consistent_hash_ring_core #(
  parameter int VNODES    = chr_pkg::VNODES_DEF,
  parameter int MAX_NODES = chr_pkg::MAX_NODES_DEF,
  parameter int MAX_NAME  = chr_pkg::MAX_NAME_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  chr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output chr_pkg::out_item_t out_data
);
  import chr_pkg::*;

  cmd_t f_cmd, q_cmd;
  logic f_valid, f_ready, q_valid, q_ready, f_last, q_last;

  // f_last: command closes its transaction (last virtual node of an add)
  chr_front #(.VNODES(VNODES), .MAX_NAME(MAX_NAME)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd_data(f_cmd), .cmd_last(f_last)
  );

  chr_queue u_queue (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd), .wr_last(f_last),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd), .rd_last(q_last)
  );

  chr_back #(.RING(VNODES * MAX_NODES)) u_back (
    .clk, .rst_n,
    .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd_data(q_cmd), .cmd_last(q_last),
    .out_valid, .out_ready, .out_data
  );

endmodule

// File: hw/rtl/chr_front.sv
// Front end: takes input transactions, keeps name store and key hash,
// hashes names per virtual node and issues commands. Depends on chr_pkg.
module chr_front #(
  parameter int VNODES   = chr_pkg::VNODES_DEF,
  parameter int MAX_NAME = chr_pkg::MAX_NAME_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  chr_pkg::in_item_t in_data,
  output logic             cmd_valid,
  input  logic             cmd_ready,
  output chr_pkg::cmd_t    cmd_data,
  output logic             cmd_last
);
  import chr_pkg::*;

  localparam int NW = $clog2(MAX_NAME + 1);
  localparam int AW = (MAX_NAME > 1) ? $clog2(MAX_NAME) : 1;
  localparam int VW = (VNODES > 1) ? $clog2(VNODES) : 1;

  logic [7:0]    name_mem [MAX_NAME];
  logic [7:0]    rd_byte_r;
  logic [NW-1:0] name_len_r, name_len_nxt;
  logic [NW-1:0] rd_idx_r, rd_idx_nxt;
  logic [31:0]   key_acc_r, key_acc_nxt;
  logic [31:0]   base_r, base_nxt;
  logic [31:0]   vh_r, vh_nxt;
  logic [VW-1:0] vn_r, vn_nxt;
  logic [3:0]    slot_r, slot_nxt;
  fe_state_t     state_r, state_nxt;
  logic          wr_en;
  logic          rd_pending_r, rd_pending_nxt;
  logic [3:0]    tens_r, tens_nxt;
  logic [3:0]    ones_r, ones_nxt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      name_mem[name_len_r[AW-1:0]] <= in_data.data_byte;
    end
    rd_byte_r <= name_mem[rd_idx_nxt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= FE_IDLE;
      name_len_r   <= '0;
      key_acc_r    <= FNV_BASIS;
      rd_idx_r     <= '0;
      rd_pending_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      name_len_r   <= name_len_nxt;
      key_acc_r    <= key_acc_nxt;
      rd_idx_r     <= rd_idx_nxt;
      rd_pending_r <= rd_pending_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    vh_r   <= vh_nxt;
    vn_r   <= vn_nxt;
    slot_r <= slot_nxt;
    tens_r <= tens_nxt;
    ones_r <= ones_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    name_len_nxt   = name_len_r;
    key_acc_nxt    = key_acc_r;
    rd_idx_nxt     = rd_idx_r;
    rd_pending_nxt = 1'b0;
    base_nxt       = base_r;
    vh_nxt         = vh_r;
    vn_nxt         = vn_r;
    slot_nxt       = slot_r;
    tens_nxt       = tens_r;
    ones_nxt       = ones_r;
    wr_en          = 1'b0;
    in_ready       = 1'b0;
    cmd_valid      = 1'b0;
    cmd_last       = 1'b1;
    cmd_data.kind  = CMD_ADD;
    cmd_data.slot  = slot_r;
    cmd_data.hash  = vh_r;
    case (state_r)
      FE_IDLE: begin
        in_ready = 1'b1;
        if (in_data.operation == OP_REMOVE ||
            (in_data.operation == OP_LOOKUP && in_data.last)) begin
          in_ready = cmd_ready;
        end
        if (in_valid && in_ready) begin
          case (in_data.operation)
            OP_ADD: begin
              if (name_len_r < NW'(MAX_NAME)) begin
                wr_en        = 1'b1;
                name_len_nxt = name_len_r + 1'b1;
              end
              if (in_data.last) begin
                slot_nxt   = in_data.node_slot;
                base_nxt   = FNV_BASIS;
                rd_idx_nxt = '0;
                state_nxt  = FE_NAME;
              end
            end
            OP_LOOKUP: begin
              key_acc_nxt = fnv_mix(key_acc_r, in_data.data_byte);
              if (in_data.last) begin
                cmd_valid     = 1'b1;
                cmd_data.kind = CMD_LOOKUP;
                cmd_data.hash = fnv_mix(key_acc_r, in_data.data_byte);
                key_acc_nxt   = FNV_BASIS;
              end
            end
            OP_REMOVE: begin
              cmd_valid     = 1'b1;
              cmd_data.kind = CMD_REMOVE;
              cmd_data.slot = in_data.node_slot;
            end
            default: ;
          endcase
        end
      end
      FE_NAME: begin
        // first cycle only issues the read of byte 0, after the last write
        // rd_byte_r holds byte rd_idx_r in the cycle after the read is issued
        if (rd_pending_r) begin
          base_nxt   = fnv_mix(base_r, rd_byte_r);
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
        if (rd_pending_r && rd_idx_r + 1'b1 == name_len_r) begin
          state_nxt = FE_COLON;
        end else begin
          rd_pending_nxt = 1'b1;
        end
      end
      FE_COLON: begin
        base_nxt  = fnv_mix(base_r, 8'h3A);
        vn_nxt    = '0;
        tens_nxt  = 4'd0;
        ones_nxt  = 4'd0;
        state_nxt = FE_TENS;
      end
      FE_TENS: begin
        vh_nxt    = (tens_r != 4'd0) ? fnv_mix(base_r, 8'h30 + 8'(tens_r)) : base_r;
        state_nxt = FE_ONES;
      end
      FE_ONES: begin
        vh_nxt    = fnv_mix(vh_r, 8'h30 + 8'(ones_r));
        state_nxt = FE_PUSH;
      end
      FE_PUSH: begin
        cmd_valid     = 1'b1;
        cmd_data.kind = CMD_ADD;
        cmd_data.slot = slot_r;
        cmd_data.hash = vh_r;
        // final virtual node of this name closes the add
        cmd_last      = (32'(vn_r) == 32'(VNODES - 1));
        if (cmd_ready) begin
          if (32'(vn_r) == 32'(VNODES - 1)) begin
            name_len_nxt = '0;
            state_nxt    = FE_IDLE;
          end else begin
            vn_nxt    = vn_r + 1'b1;
            // decimal digits of the virtual node index
            if (ones_r == 4'd9) begin
              ones_nxt = 4'd0;
              tens_nxt = tens_r + 4'd1;
            end else begin
              ones_nxt = ones_r + 4'd1;
            end
            state_nxt = FE_TENS;
          end
        end
      end
      default: state_nxt = FE_IDLE;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && state_r == FE_PUSH && !cmd_valid)
      $error("push without valid");
  end

  property p_len_bound;
    @(posedge clk) disable iff (!rst_n) name_len_r <= NW'(MAX_NAME);
  endproperty
  assert property (p_len_bound) else $error("name length overflow");

  property p_idle_after_push;
    @(posedge clk) disable iff (!rst_n)
      (state_r == FE_PUSH && cmd_ready && 32'(vn_r) == 32'(VNODES - 1)) |=>
      (state_r == FE_IDLE && name_len_r == '0);
  endproperty
  assert property (p_idle_after_push) else $error("add did not finish");

  property p_key_reset;
    @(posedge clk) disable iff (!rst_n)
      (state_r == FE_IDLE && in_valid && in_ready &&
       in_data.operation == OP_LOOKUP && in_data.last) |=> key_acc_r == FNV_BASIS;
  endproperty
  assert property (p_key_reset) else $error("key hash not reset");

endmodule

// File: hw/rtl/chr_queue.sv
// Two-entry command queue between front and back ends. Depends on chr_pkg.
module chr_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  chr_pkg::cmd_t wr_data,
  input  logic          wr_last,
  output logic          rd_valid,
  input  logic          rd_ready,
  output chr_pkg::cmd_t rd_data,
  output logic          rd_last
);
  import chr_pkg::*;

  cmd_t       mem_r [2];
  logic       lst_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem_r[rp_r];
  assign rd_last  = lst_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_data;
      lst_r[wp_r] <= wr_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  property p_cnt;
    @(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2;
  endproperty
  assert property (p_cnt) else $error("queue count out of range");

  property p_cnt_step;
    @(posedge clk) disable iff (!rst_n)
      (push && !pop) |=> cnt_r == $past(cnt_r) + 2'd1;
  endproperty
  assert property (p_cnt_step) else $error("queue count lost a push");

  property p_hold;
    @(posedge clk) disable iff (!rst_n)
      (rd_valid && !rd_ready && cnt_r == 2'd2) |=> $stable(rp_r);
  endproperty
  assert property (p_hold) else $error("queue read pointer moved on stall");

endmodule

// File: hw/rtl/chr_back.sv
// Back end: ring table memory with per-entry valid bits, scan engine for
// insert, lookup and remove, and the output register. Depends on chr_pkg.
module chr_back #(
  parameter int RING = chr_pkg::VNODES_DEF * chr_pkg::MAX_NODES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  chr_pkg::cmd_t     cmd_data,
  input  logic              cmd_last,
  output logic              out_valid,
  input  logic              out_ready,
  output chr_pkg::out_item_t out_data
);
  import chr_pkg::*;

  localparam int IW = (RING > 1) ? $clog2(RING) : 1;
  localparam int CW = $clog2(RING + 1);

  logic [31:0]   hash_mem [RING];
  logic [3:0]    slot_mem [RING];
  logic [RING-1:0] vld_r;

  be_state_t     state_r, state_nxt;
  cmd_t          cmd_r;
  logic          last_r;
  logic [CW-1:0] idx_r;         // entry address being issued
  logic [IW-1:0] rd_idx_r;      // address of data in rd_*_r
  logic          rd_ok_r;
  logic [31:0]   rd_hash_r;
  logic [3:0]    rd_slot_r;
  logic          any_r, found_r, match_r, free_ok_r, drop_r;
  logic [31:0]   min_h_r, best_h_r;
  logic [3:0]    min_s_r, best_s_r;
  logic [IW-1:0] match_idx_r, free_idx_r;
  logic          wr_en;
  logic [IW-1:0] wr_idx;
  logic          out_load;
  out_item_t     out_nxt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hash_mem[wr_idx] <= cmd_r.hash;
      slot_mem[wr_idx] <= cmd_r.slot;
    end
    rd_hash_r <= hash_mem[idx_r[IW-1:0]];
    rd_slot_r <= slot_mem[idx_r[IW-1:0]];
  end

  assign cmd_ready = (state_r == BE_IDLE);
  assign wr_idx    = match_r ? match_idx_r : free_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BE_IDLE;
      vld_r     <= '0;
      out_valid <= 1'b0;
      drop_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (wr_en) vld_r[wr_idx] <= 1'b1;
      if (state_r == BE_WRITE && cmd_r.kind == CMD_ADD && !match_r && !free_ok_r)
        drop_r <= 1'b1;
      if (out_load) drop_r <= 1'b0;
      if (state_r == BE_SCAN && rd_ok_r && cmd_r.kind == CMD_REMOVE &&
          vld_r[rd_idx_r] && rd_slot_r == cmd_r.slot)
        vld_r[rd_idx_r] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data <= out_nxt;
  end

  // Scan: address issued at idx_r, data seen in the next cycle.
  always_ff @(posedge clk) begin
    if (state_r == BE_IDLE && cmd_valid) begin
      cmd_r     <= cmd_data;
      last_r    <= cmd_last;
      idx_r     <= '0;
      rd_ok_r   <= 1'b0;
      any_r     <= 1'b0;
      found_r   <= 1'b0;
      match_r   <= 1'b0;
      free_ok_r <= 1'b0;
    end else if (state_r == BE_SCAN) begin
      if (idx_r != CW'(RING)) idx_r <= idx_r + 1'b1;
      rd_ok_r  <= idx_r != CW'(RING);
      rd_idx_r <= idx_r[IW-1:0];
      if (rd_ok_r) begin
        if (vld_r[rd_idx_r]) begin
          if (!any_r || rd_hash_r < min_h_r) begin
            min_h_r <= rd_hash_r;
            min_s_r <= rd_slot_r;
          end
          any_r <= 1'b1;
          if (rd_hash_r >= cmd_r.hash && (!found_r || rd_hash_r < best_h_r)) begin
            best_h_r <= rd_hash_r;
            best_s_r <= rd_slot_r;
            found_r  <= 1'b1;
          end
          if (rd_hash_r == cmd_r.hash && !match_r) begin
            match_r     <= 1'b1;
            match_idx_r <= rd_idx_r;
          end
        end else if (!free_ok_r) begin
          free_ok_r  <= 1'b1;
          free_idx_r <= rd_idx_r;
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    wr_en     = 1'b0;
    out_load  = 1'b0;
    out_nxt   = '0;
    case (state_r)
      BE_IDLE: if (cmd_valid) state_nxt = BE_SCAN;
      BE_SCAN: if (rd_ok_r && 32'(rd_idx_r) == 32'(RING - 1))
        state_nxt = (cmd_r.kind == CMD_ADD) ? BE_WRITE : BE_RESULT;
      BE_WRITE: begin
        wr_en     = match_r || free_ok_r;
        state_nxt = last_r ? BE_RESULT : BE_IDLE;
      end
      BE_RESULT: begin
        if (!out_valid || out_ready) begin
          out_load = 1'b1;
          case (cmd_r.kind)
            CMD_LOOKUP: begin
              out_nxt.key_digest = cmd_r.hash;
              if (!any_r) begin
                out_nxt.status = ST_EMPTY;
              end else begin
                out_nxt.status     = ST_FOUND;
                out_nxt.owner_slot = found_r ? best_s_r : min_s_r;
              end
            end
            CMD_ADD: out_nxt.status = drop_r ? ST_FULL : ST_DONE;
            default: out_nxt.status = ST_DONE;
          endcase
          state_nxt = BE_IDLE;
        end
      end
      default: state_nxt = BE_IDLE;
    endcase
  end

  property p_out_hold;
    @(posedge clk) disable iff (!rst_n)
      (out_valid && !out_ready) |=> $stable(out_data);
  endproperty
  assert property (p_out_hold) else $error("result overwritten");

  property p_write_valid;
    @(posedge clk) disable iff (!rst_n) wr_en |=> vld_r[$past(wr_idx)];
  endproperty
  assert property (p_write_valid) else $error("written entry not valid");

  property p_busy;
    @(posedge clk) disable iff (!rst_n) (state_r != BE_IDLE) |-> !cmd_ready;
  endproperty
  assert property (p_busy) else $error("accepted command while busy");

endmodule
